### hw/rtl/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
package mer_pkg;

    localparam int OUT_BITS    = 14;
    localparam int OUT_TDATA_W = 4 * OUT_BITS;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_STEP,
        UOP_SQ_A,
        UOP_SQ_B,
        UOP_SQ_AB,
        UOP_INIT,
        UOP_R2_TX,
        UOP_R2_BT,
        UOP_R2_TY,
        UOP_R2_AU,
        UOP_R2_AB,
        UOP_R2_FIN
    } t_uop;

    typedef struct packed {
        logic active;
        logic need_r2;
        logic out_full;
    } t_dp_status;

endpackage

### hw/rtl/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer.
// A start transfer (tuser = 0) loads center and semi-axes in the accept cycle; then, in
// states SQ_A, SQ_B, SQ_AB and INIT, one shared multiplier forms a^2, b^2 and
// a^2*b for the initial decision. Each step transfer (tuser = 1) emits the four
// symmetric coordinates of the current point into the output register, valid on the
// cycle after the transfer, and advances the point; the step that crosses into region
// two is followed by states R2_TX, R2_BT, R2_TY, R2_AU, R2_AB and R2_FIN, since the
// region-two decision needs five chained products through the same multiplier. The input
// is ready only while the output register is empty or drained by m_axis_tready in the
// same cycle, so a result left waiting holds off every input transfer. tlast marks the
// final point set; steps with no ellipse active are consumed without a result.
module midpoint_ellipse_rasterizer #(
    parameter int AXIS_BITS  = 11,
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // center_x, center_y, horiz_axis, vert_axis, zero fill
    input  logic [((2*COORD_BITS+2*AXIS_BITS+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // x_right, x_left, y_up, y_down
    output logic [mer_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);
    import mer_pkg::*;

    localparam int CY_LO = COORD_BITS;
    localparam int HA_LO = 2 * COORD_BITS;
    localparam int VA_LO = 2 * COORD_BITS + AXIS_BITS;

    t_uop                uop;
    t_dp_status          status;
    logic [OUT_BITS-1:0] x_right, x_left, y_up, y_down;

    mer_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_mode    (s_axis_tuser),
        .i_m_ready (m_axis_tready),
        .i_status  (status),
        .o_s_ready (s_axis_tready),
        .o_uop     (uop)
    );

    mer_datapath #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uop        (uop),
        .i_center_x   (s_axis_tdata[COORD_BITS-1:0]),
        .i_center_y   (s_axis_tdata[CY_LO +: COORD_BITS]),
        .i_horiz_axis (s_axis_tdata[HA_LO +: AXIS_BITS]),
        .i_vert_axis  (s_axis_tdata[VA_LO +: AXIS_BITS]),
        .i_m_ready    (m_axis_tready),
        .o_status     (status),
        .o_m_valid    (m_axis_tvalid),
        .o_x_right    (x_right),
        .o_x_left     (x_left),
        .o_y_up       (y_up),
        .o_y_down     (y_down),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {y_down, y_up, x_left, x_right};

endmodule

### hw/rtl/mer_datapath.sv
// Datapath: point registers, decision accumulators, shared multiplier, output register.
module mer_datapath #(
    parameter int AXIS_BITS  = 11,
    parameter int COORD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mer_pkg::t_uop               i_uop,
    input  logic [COORD_BITS-1:0]       i_center_x,
    input  logic [COORD_BITS-1:0]       i_center_y,
    input  logic [AXIS_BITS-1:0]        i_horiz_axis,
    input  logic [AXIS_BITS-1:0]        i_vert_axis,
    input  logic                        i_m_ready,
    output mer_pkg::t_dp_status         o_status,
    output logic                        o_m_valid,
    output logic [mer_pkg::OUT_BITS-1:0] o_x_right,
    output logic [mer_pkg::OUT_BITS-1:0] o_x_left,
    output logic [mer_pkg::OUT_BITS-1:0] o_y_up,
    output logic [mer_pkg::OUT_BITS-1:0] o_y_down,
    output logic                        o_last
);
    import mer_pkg::*;

    localparam int SQ_BITS = 2 * AXIS_BITS;
    localparam int X_BITS  = AXIS_BITS + 2;
    localparam int M_BITS  = 2 * AXIS_BITS + 4;
    localparam int D_BITS  = 4 * AXIS_BITS + 4;

    logic [COORD_BITS-1:0]    r_cx, r_cy;
    logic [AXIS_BITS-1:0]     r_a, r_b;
    logic [SQ_BITS-1:0]       r_a2, r_b2;
    logic [X_BITS-1:0]        r_x;
    logic signed [X_BITS-1:0] r_y;
    logic signed [D_BITS-1:0] r_px, r_py, r_d, r_acc;
    logic [D_BITS-1:0]        r_prod;
    logic                     r_region, r_active, r_out_valid, r_last;
    logic [OUT_BITS-1:0]      r_xr, r_xl, r_yu, r_yd;

    logic [X_BITS-1:0]        n_x;
    logic signed [X_BITS-1:0] n_y;
    logic signed [D_BITS-1:0] n_px, n_py, n_d, term;
    logic signed [D_BITS-1:0] a2_ext, b2_ext, prod_s;
    logic signed [D_BITS-1:0] cx_ext, cy_ext, x_ext, y_ext;
    logic signed [D_BITS-1:0] sum_xr, sum_xl, sum_yu, sum_yd;
    logic                     y_neg, need_r2;
    logic [X_BITS:0]          tx;
    logic [X_BITS-1:0]        ty_abs;
    logic [M_BITS-1:0]        op_a, op_b;
    logic [2*M_BITS-1:0]      mul_full;

    assign a2_ext = $signed(D_BITS'(r_a2));
    assign b2_ext = $signed(D_BITS'(r_b2));
    assign prod_s = $signed(r_prod);

    always_comb begin
        n_x  = r_x;
        n_y  = r_y;
        n_px = r_px;
        n_py = r_py;
        term = '0;
        if (!r_region) begin
            n_x  = r_x + X_BITS'(1);
            n_px = r_px + (b2_ext <<< 1);
            if (r_d[D_BITS-1]) begin
                term = n_px + b2_ext;
            end else begin
                n_y  = r_y - X_BITS'(1);
                n_py = r_py - (a2_ext <<< 1);
                term = n_px - n_py + b2_ext;
            end
        end else begin
            n_y  = r_y - X_BITS'(1);
            n_py = r_py - (a2_ext <<< 1);
            if (!r_d[D_BITS-1] && (r_d != '0)) begin
                term = a2_ext - n_py;
            end else begin
                n_x  = r_x + X_BITS'(1);
                n_px = r_px + (b2_ext <<< 1);
                term = n_px - n_py + a2_ext;
            end
        end
        n_d     = r_d + (term <<< 2);
        y_neg   = n_y[X_BITS-1];
        need_r2 = !r_region && !y_neg && (n_px > n_py);
    end

    assign cx_ext = $signed(D_BITS'(r_cx));
    assign cy_ext = $signed(D_BITS'(r_cy));
    assign x_ext  = $signed(D_BITS'(r_x));
    assign y_ext  = D_BITS'(r_y);
    assign sum_xr = cx_ext + x_ext;
    assign sum_xl = cx_ext - x_ext;
    assign sum_yu = cy_ext - y_ext;
    assign sum_yd = cy_ext + y_ext;

    assign tx     = {r_x, 1'b1};
    assign ty_abs = (r_y == '0) ? X_BITS'(1) : X_BITS'(r_y - X_BITS'(1));

    always_comb begin
        unique case (i_uop)
            UOP_SQ_A: begin
                op_a = M_BITS'(r_a);
                op_b = M_BITS'(r_a);
            end
            UOP_SQ_B: begin
                op_a = M_BITS'(r_b);
                op_b = M_BITS'(r_b);
            end
            UOP_SQ_AB: begin
                op_a = M_BITS'(r_a2);
                op_b = M_BITS'(r_b);
            end
            UOP_R2_TX: begin
                op_a = M_BITS'(tx);
                op_b = M_BITS'(tx);
            end
            UOP_R2_BT: begin
                op_a = M_BITS'(r_b2);
                op_b = r_prod[M_BITS-1:0];
            end
            UOP_R2_TY: begin
                op_a = M_BITS'(ty_abs);
                op_b = M_BITS'(ty_abs);
            end
            UOP_R2_AU: begin
                op_a = M_BITS'(r_a2);
                op_b = r_prod[M_BITS-1:0];
            end
            UOP_R2_AB: begin
                op_a = M_BITS'(r_a2);
                op_b = M_BITS'(r_b2);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_full = op_a * op_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region    <= 1'b0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_uop == UOP_STEP) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_uop == UOP_LOAD) begin
                r_region <= 1'b0;
                r_active <= 1'b1;
            end else if (i_uop == UOP_STEP) begin
                if (!r_region && (y_neg || need_r2)) begin
                    r_region <= 1'b1;
                end
                if (y_neg) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[D_BITS-1:0];
        unique case (i_uop)
            UOP_LOAD: begin
                r_cx <= i_center_x;
                r_cy <= i_center_y;
                r_a  <= i_horiz_axis;
                r_b  <= i_vert_axis;
                r_x  <= '0;
                r_y  <= $signed(X_BITS'(i_vert_axis));
            end
            UOP_STEP: begin
                r_xr   <= sum_xr[OUT_BITS-1:0];
                r_xl   <= sum_xl[OUT_BITS-1:0];
                r_yu   <= sum_yu[OUT_BITS-1:0];
                r_yd   <= sum_yd[OUT_BITS-1:0];
                r_last <= y_neg;
                r_x    <= n_x;
                r_y    <= n_y;
                r_px   <= n_px;
                r_py   <= n_py;
                r_d    <= n_d;
            end
            UOP_SQ_B: begin
                r_a2 <= r_prod[SQ_BITS-1:0];
            end
            UOP_SQ_AB: begin
                r_b2 <= r_prod[SQ_BITS-1:0];
            end
            UOP_INIT: begin
                r_d  <= (b2_ext <<< 2) - (prod_s <<< 2) + a2_ext;
                r_py <= prod_s <<< 1;
                r_px <= '0;
            end
            UOP_R2_TY: begin
                r_acc <= prod_s;
            end
            UOP_R2_AB: begin
                r_acc <= r_acc + (prod_s <<< 2);
            end
            UOP_R2_FIN: begin
                r_d <= r_acc - (prod_s <<< 2);
            end
            default: begin
            end
        endcase
    end

    assign o_status.active   = r_active;
    assign o_status.need_r2  = need_r2;
    assign o_status.out_full = r_out_valid;
    assign o_m_valid         = r_out_valid;
    assign o_x_right         = r_xr;
    assign o_x_left          = r_xl;
    assign o_y_up            = r_yu;
    assign o_y_down          = r_yd;
    assign o_last            = r_last;

endmodule

### hw/rtl/mer_ctrl.sv
// Controller: input handshake and micro-op sequencer for setup and region switch.
module mer_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  logic                i_mode,
    input  logic                i_m_ready,
    input  mer_pkg::t_dp_status i_status,
    output logic                o_s_ready,
    output mer_pkg::t_uop       o_uop
);
    import mer_pkg::*;

    typedef enum logic [3:0] {
        S_READY,
        S_SQ_A,
        S_SQ_B,
        S_SQ_AB,
        S_INIT,
        S_R2_TX,
        S_R2_BT,
        S_R2_TY,
        S_R2_AU,
        S_R2_AB,
        S_R2_FIN
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_s_ready = (r_state == S_READY) && (!i_status.out_full || i_m_ready);
    assign accept    = i_s_valid && o_s_ready;

    always_comb begin
        n_state = r_state;
        o_uop   = UOP_NONE;
        unique case (r_state)
            S_READY: begin
                if (accept) begin
                    if (i_mode == MODE_START) begin
                        o_uop   = UOP_LOAD;
                        n_state = S_SQ_A;
                    end else if (i_status.active) begin
                        o_uop = UOP_STEP;
                        if (i_status.need_r2) begin
                            n_state = S_R2_TX;
                        end
                    end
                end
            end
            S_SQ_A: begin
                o_uop   = UOP_SQ_A;
                n_state = S_SQ_B;
            end
            S_SQ_B: begin
                o_uop   = UOP_SQ_B;
                n_state = S_SQ_AB;
            end
            S_SQ_AB: begin
                o_uop   = UOP_SQ_AB;
                n_state = S_INIT;
            end
            S_INIT: begin
                o_uop   = UOP_INIT;
                n_state = S_READY;
            end
            S_R2_TX: begin
                o_uop   = UOP_R2_TX;
                n_state = S_R2_BT;
            end
            S_R2_BT: begin
                o_uop   = UOP_R2_BT;
                n_state = S_R2_TY;
            end
            S_R2_TY: begin
                o_uop   = UOP_R2_TY;
                n_state = S_R2_AU;
            end
            S_R2_AU: begin
                o_uop   = UOP_R2_AU;
                n_state = S_R2_AB;
            end
            S_R2_AB: begin
                o_uop   = UOP_R2_AB;
                n_state = S_R2_FIN;
            end
            S_R2_FIN: begin
                o_uop   = UOP_R2_FIN;
                n_state = S_READY;
            end
            default: begin
                n_state = S_READY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_READY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/mer_checker.sv
// Port-level checker for the midpoint ellipse rasterizer, bound to the top level.
module mer_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mer_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import mer_pkg::*;

    logic start_xfer, step_xfer;

    assign start_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_START);
    assign step_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_STEP);

    a_start_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_xfer |=> !s_axis_tready)
        else $error("input ready right after a start transfer");

    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(step_xfer))
        else $error("result appeared without a step transfer");

    a_start_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start_xfer && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("start transfer produced a result");

    a_hold_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
